[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST  = 11'd101;
  localparam logic [CFG_W-1:0] MAX_DELETED_RST = 11'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE  = 2'd0,
    CFG_MAX_DELETED = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_ACTIVE  = 2'd1,
    TAG_DELETED = 2'd2
  } tag_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_MOD      = 10'b00_0000_0100,
    S_PRB_RD   = 10'b00_0000_1000,
    S_PRB_CHK  = 10'b00_0001_0000,
    S_SCAN_RD  = 10'b00_0010_0000,
    S_SCAN_CHK = 10'b00_0100_0000,
    S_BUF_RD   = 10'b00_1000_0000,
    S_BUF_WAIT = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

endpackage

[sv/lpht_req_if.sv]
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: operation and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [lpht_pkg::KEY_IN_W-1:0]   key_value;

  modport source (output valid, output operation, output key_value, input ready);
  modport sink   (input valid, input operation, input key_value, output ready);
endinterface

[sv/lpht_rsp_if.sv]
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: status and counts, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::STATUS_W-1:0]   status;
  logic [lpht_pkg::COUNT_W-1:0]    active_count;
  logic [lpht_pkg::COUNT_W-1:0]    deleted_count;
  logic                            rebuilt;
  logic                            half_full;

  modport source (output valid, output status, output active_count, output deleted_count,
                  output rebuilt, output half_full, input ready);
  modport sink   (input valid, input status, input active_count, input deleted_count,
                  input rebuilt, input half_full, output ready);
endinterface

[sv/lpht_ram.sv]
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash set with linear probing and deleted marks.
// ----------------------------------------------------------------------------
// req_i carries one beat per operation (insert or remove of a key); rsp_o
// returns one beat per request with status, active and deleted counts and the
// rebuild and half full flags. cfg_we_i writes table_size (index 0) or
// max_deleted (index 1); the user must do so only while the block is idle.
// The block does not enforce this. Each request is accepted, passes through
// the shared bit-serial modulo unit for the home slot, probes the slot memory
// (read, then check) slot by slot, and then loads the response register.
// A remove that trips a rebuild then scans every slot in use, moving live
// keys to a buffer memory, and re-hashes and re-places each surviving key
// before the response.
// After reset and after every table_size write the slot memory is swept
// empty, one entry a cycle over all CAPACITY entries; req_i.ready stays low then.
// The response sits in an output register; a stalled receiver holds it, and
// the block takes the next request meanwhile but cannot finish it until the
// register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lpht_req_if.sink                         req_i,
  lpht_rsp_if.source                       rsp_o,
  input  logic                             cfg_we_i,
  input  logic [lpht_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpht_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SZ_W  = (CNT_W > lpht_pkg::CFG_W) ? CNT_W : lpht_pkg::CFG_W;
  localparam int unsigned KB_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned KIN_W = (KEY_BITS < lpht_pkg::KEY_IN_W) ? KEY_BITS
                                                                   : lpht_pkg::KEY_IN_W;
  localparam int unsigned SLOT_W = KEY_BITS + 2;

  lpht_pkg::state_e            state_q, state_d;
  logic [IDX_W-1:0]            clr_idx_q, clr_idx_d;
  logic [lpht_pkg::CFG_W-1:0]  tsize_q, tsize_d;
  logic [lpht_pkg::CFG_W-1:0]  maxdel_q, maxdel_d;
  logic [KEY_BITS-1:0]         key_q, key_d;
  lpht_pkg::op_e               op_q, op_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  logic [KB_W-1:0]             bit_q, bit_d;
  logic [IDX_W-1:0]            pos_q, pos_d;
  logic [CNT_W-1:0]            prb_q, prb_d;
  logic [CNT_W-1:0]            act_q, act_d;
  logic [CNT_W-1:0]            del_q, del_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CNT_W-1:0]            ridx_q, ridx_d;
  logic                        rbmode_q, rbmode_d;
  logic                        rebuilt_q, rebuilt_d;
  lpht_pkg::status_e           status_q, status_d;

  logic                                out_valid_q, out_valid_d;
  logic [lpht_pkg::STATUS_W-1:0]       out_status_q, out_status_d;
  logic [lpht_pkg::COUNT_W-1:0]        out_act_q, out_act_d;
  logic [lpht_pkg::COUNT_W-1:0]        out_del_q, out_del_d;
  logic                                out_rebuilt_q, out_rebuilt_d;
  logic                                out_half_q, out_half_d;

  // slot memory: {tag, key}
  logic               slot_we, slot_re;
  logic [IDX_W-1:0]   slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
  logic               buf_we, buf_re;
  logic [IDX_W-1:0]   buf_waddr, buf_raddr;
  logic [KEY_BITS-1:0] buf_wdata, buf_rdata;

  lpht_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // slots in use
  logic [SZ_W-1:0]  tsize_ext;
  logic [CNT_W-1:0] n_slots;
  always_comb begin
    tsize_ext = SZ_W'(tsize_q);
    if (tsize_ext == '0) begin
      n_slots = CNT_W'(1);
    end else if (tsize_ext > SZ_W'(CAPACITY)) begin
      n_slots = CNT_W'(CAPACITY);
    end else begin
      n_slots = CNT_W'(tsize_ext);
    end
  end

  // shared modulo unit: one dividend bit per cycle
  logic [CNT_W:0]   rem_sh, rem_sub;
  logic [CNT_W-1:0] rem_nxt;
  always_comb begin
    rem_sh  = {rem_q, key_q[bit_q]};
    rem_sub = rem_sh - {1'b0, n_slots};
    rem_nxt = (rem_sh >= {1'b0, n_slots}) ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  end

  logic [CNT_W-1:0]    pos_p1, prb_p1, del_p1;
  logic [IDX_W-1:0]    pos_wrap;
  lpht_pkg::tag_e      rd_tag;
  logic [KEY_BITS-1:0] rd_key;
  logic [SZ_W-1:0]     del_p1_ext, maxdel_ext;
  logic                half_w;

  assign pos_p1   = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_wrap = (pos_p1 >= n_slots) ? '0 : pos_p1[IDX_W-1:0];
  assign prb_p1   = prb_q + CNT_W'(1);
  assign del_p1   = del_q + CNT_W'(1);
  assign rd_tag   = lpht_pkg::tag_e'(slot_rdata[SLOT_W-1:KEY_BITS]);
  assign rd_key   = slot_rdata[KEY_BITS-1:0];
  assign del_p1_ext = SZ_W'(del_p1);
  assign maxdel_ext = SZ_W'(maxdel_q);
  assign half_w   = (act_q >= (n_slots >> 1));

  // no request beat is taken while a register write is under way
  assign req_i.ready = (state_q == lpht_pkg::S_IDLE) && !cfg_we_i;

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    tsize_d   = tsize_q;
    maxdel_d  = maxdel_q;
    key_d     = key_q;
    op_d      = op_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    pos_d     = pos_q;
    prb_d     = prb_q;
    act_d     = act_q;
    del_d     = del_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    rbmode_d  = rbmode_q;
    rebuilt_d = rebuilt_q;
    status_d  = status_q;

    out_valid_d   = out_valid_q & ~rsp_o.ready;
    out_status_d  = out_status_q;
    out_act_d     = out_act_q;
    out_del_d     = out_del_q;
    out_rebuilt_d = out_rebuilt_q;
    out_half_d    = out_half_q;

    slot_we    = 1'b0;
    slot_waddr = pos_q;
    slot_wdata = {lpht_pkg::TAG_ACTIVE, key_q};
    slot_re    = 1'b0;
    slot_raddr = pos_q;
    buf_we     = 1'b0;
    buf_waddr  = cnt_q[IDX_W-1:0];
    buf_wdata  = rd_key;
    buf_re     = 1'b0;
    buf_raddr  = ridx_q[IDX_W-1:0];

    if (cfg_we_i) begin
      if (cfg_idx_i == lpht_pkg::CFG_TABLE_SIZE) begin
        tsize_d   = cfg_data_i;
        clr_idx_d = '0;
        act_d     = '0;
        del_d     = '0;
        state_d   = lpht_pkg::S_CLEAR;
      end else if (cfg_idx_i == lpht_pkg::CFG_MAX_DELETED) begin
        maxdel_d = cfg_data_i;
      end
    end

    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx_q;
        slot_wdata = '0;
        act_d      = '0;
        del_d      = '0;
        if (CNT_W'(clr_idx_q) == CNT_W'(CAPACITY - 1)) begin
          if (!cfg_we_i) state_d = lpht_pkg::S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + IDX_W'(1);
        end
      end
      lpht_pkg::S_IDLE: begin
        if (req_i.valid && !cfg_we_i) begin
          key_d     = KEY_BITS'(req_i.key_value[KIN_W-1:0]);
          op_d      = lpht_pkg::op_e'(req_i.operation);
          rem_d     = '0;
          bit_d     = KB_W'(KEY_BITS - 1);
          rbmode_d  = 1'b0;
          rebuilt_d = 1'b0;
          state_d   = lpht_pkg::S_MOD;
        end
      end
      lpht_pkg::S_MOD: begin
        rem_d = rem_nxt;
        if (bit_q == '0) begin
          pos_d   = rem_nxt[IDX_W-1:0];
          prb_d   = '0;
          state_d = lpht_pkg::S_PRB_RD;
        end else begin
          bit_d = bit_q - KB_W'(1);
        end
      end
      lpht_pkg::S_PRB_RD: begin
        slot_re    = 1'b1;
        slot_raddr = pos_q;
        state_d    = lpht_pkg::S_PRB_CHK;
      end
      lpht_pkg::S_PRB_CHK: begin
        if (op_q == lpht_pkg::OP_INSERT || rbmode_q) begin
          if (rd_tag != lpht_pkg::TAG_ACTIVE) begin
            slot_we = 1'b1;
            if (rd_tag == lpht_pkg::TAG_DELETED && del_q != '0) begin
              del_d = del_q - CNT_W'(1);
            end
            act_d    = act_q + CNT_W'(1);
            status_d = lpht_pkg::ST_INSERTED;
            if (rbmode_q) begin
              ridx_d  = ridx_q + CNT_W'(1);
              state_d = lpht_pkg::S_BUF_RD;
            end else begin
              state_d = lpht_pkg::S_RESP;
            end
          end else if (rd_key == key_q && !rbmode_q) begin
            status_d = lpht_pkg::ST_PRESENT;
            state_d  = lpht_pkg::S_RESP;
          end else if (prb_p1 == n_slots) begin
            status_d = lpht_pkg::ST_FULL;
            if (rbmode_q) begin
              ridx_d  = ridx_q + CNT_W'(1);
              state_d = lpht_pkg::S_BUF_RD;
            end else begin
              state_d = lpht_pkg::S_RESP;
            end
          end else begin
            pos_d   = pos_wrap;
            prb_d   = prb_p1;
            state_d = lpht_pkg::S_PRB_RD;
          end
        end else begin
          if (rd_tag == lpht_pkg::TAG_EMPTY) begin
            status_d = lpht_pkg::ST_NOT_FOUND;
            state_d  = lpht_pkg::S_RESP;
          end else if (rd_tag == lpht_pkg::TAG_ACTIVE && rd_key == key_q) begin
            slot_we    = 1'b1;
            slot_wdata = {lpht_pkg::TAG_DELETED, key_q};
            del_d      = del_p1;
            if (act_q != '0) act_d = act_q - CNT_W'(1);
            status_d   = lpht_pkg::ST_REMOVED;
            if (del_p1_ext > maxdel_ext) begin
              rebuilt_d = 1'b1;
              prb_d     = '0;
              cnt_d     = '0;
              state_d   = lpht_pkg::S_SCAN_RD;
            end else begin
              state_d = lpht_pkg::S_RESP;
            end
          end else if (prb_p1 == n_slots) begin
            status_d = lpht_pkg::ST_NOT_FOUND;
            state_d  = lpht_pkg::S_RESP;
          end else begin
            pos_d   = pos_wrap;
            prb_d   = prb_p1;
            state_d = lpht_pkg::S_PRB_RD;
          end
        end
      end
      lpht_pkg::S_SCAN_RD: begin
        slot_re    = 1'b1;
        slot_raddr = prb_q[IDX_W-1:0];
        state_d    = lpht_pkg::S_SCAN_CHK;
      end
      lpht_pkg::S_SCAN_CHK: begin
        // move live keys aside and empty the slot
        if (rd_tag == lpht_pkg::TAG_ACTIVE) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        slot_we    = 1'b1;
        slot_waddr = prb_q[IDX_W-1:0];
        slot_wdata = '0;
        if (prb_p1 == n_slots) begin
          act_d    = '0;
          del_d    = '0;
          ridx_d   = '0;
          rbmode_d = 1'b1;
          state_d  = lpht_pkg::S_BUF_RD;
        end else begin
          prb_d   = prb_p1;
          state_d = lpht_pkg::S_SCAN_RD;
        end
      end
      lpht_pkg::S_BUF_RD: begin
        if (ridx_q == cnt_q) begin
          status_d = lpht_pkg::ST_REMOVED;
          rbmode_d = 1'b0;
          state_d  = lpht_pkg::S_RESP;
        end else begin
          buf_re  = 1'b1;
          state_d = lpht_pkg::S_BUF_WAIT;
        end
      end
      lpht_pkg::S_BUF_WAIT: begin
        key_d   = buf_rdata;
        rem_d   = '0;
        bit_d   = KB_W'(KEY_BITS - 1);
        state_d = lpht_pkg::S_MOD;
      end
      lpht_pkg::S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_act_d     = lpht_pkg::COUNT_W'(act_q);
          out_del_d     = lpht_pkg::COUNT_W'(del_q);
          out_rebuilt_d = rebuilt_q;
          out_half_d    = half_w;
          state_d       = lpht_pkg::S_IDLE;
        end
      end
      default: state_d = lpht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::S_CLEAR;
      clr_idx_q   <= '0;
      tsize_q     <= lpht_pkg::TABLE_SIZE_RST;
      maxdel_q    <= lpht_pkg::MAX_DELETED_RST;
      act_q       <= '0;
      del_q       <= '0;
      cnt_q       <= '0;
      ridx_q      <= '0;
      rbmode_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      tsize_q     <= tsize_d;
      maxdel_q    <= maxdel_d;
      act_q       <= act_d;
      del_q       <= del_d;
      cnt_q       <= cnt_d;
      ridx_q      <= ridx_d;
      rbmode_q    <= rbmode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    op_q          <= op_d;
    rem_q         <= rem_d;
    bit_q         <= bit_d;
    pos_q         <= pos_d;
    prb_q         <= prb_d;
    rebuilt_q     <= rebuilt_d;
    status_q      <= status_d;
    out_status_q  <= out_status_d;
    out_act_q     <= out_act_d;
    out_del_q     <= out_del_d;
    out_rebuilt_q <= out_rebuilt_d;
    out_half_q    <= out_half_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.active_count  = out_act_q;
  assign rsp_o.deleted_count = out_del_q;
  assign rsp_o.rebuilt       = out_rebuilt_q;
  assign rsp_o.half_full     = out_half_q;

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::S_IDLE) |-> ((CNT_W + 1)'(act_q) + (CNT_W + 1)'(del_q)
                                       <= (CNT_W + 1)'(n_slots)))
    else $error("active plus deleted exceeds slots in use");

  a_rebuild_clears_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rebuilt_q) |-> (out_del_q == '0))
    else $error("rebuilt response with deleted marks left");

  a_rebuild_only_on_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rebuilt_q) |-> (out_status_q == lpht_pkg::ST_REMOVED))
    else $error("rebuild flagged on a non-remove result");

  a_size_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == lpht_pkg::CFG_TABLE_SIZE) |=>
      (state_q == lpht_pkg::S_CLEAR && act_q == '0 && del_q == '0))
    else $error("table size write did not start a clearing sweep");

endmodule
